>>> src/bmhq_pkg.sv
// Shared types and codes for the binary min-heap queue.
// No dependencies; used by bmhq_store and binary_min_heap_queue.
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int TAG_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 11;

    // Command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One heap slot: signed key and its tag
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

endpackage

`default_nettype wire

>>> src/bmhq_store.sv
// Heap slot memory: one write port, two registered read ports.
// Depends on bmhq_pkg for the slot type.
`default_nettype none

module bmhq_store #(
    parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             re_a,
    input  wire logic [AW-1:0]    addr_a,
    output bmhq_pkg::entry_t      rdata_a,
    input  wire logic             re_b,
    input  wire logic [AW-1:0]    addr_b,
    output bmhq_pkg::entry_t      rdata_b,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire bmhq_pkg::entry_t wdata
);

    bmhq_pkg::entry_t mem [DEPTH];
    bmhq_pkg::entry_t rdata_a_reg;
    bmhq_pkg::entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a_reg <= mem[addr_a];
        end
        if (re_b)
        begin
            rdata_b_reg <= mem[addr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

>>> src/binary_min_heap_queue.sv
// Binary min-heap priority queue: sequencer plus heap slot memory.
// Depends on bmhq_pkg and bmhq_store.
`default_nettype none

// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   -------------------------
// command   start, busy, command, item_value,       rising edge, start && !busy
//           item_tag
// result    done, status, min_value, min_tag,       rising edge ending the one
//           occupancy                               cycle that done is high
//
// A refused command (full enqueue, empty dequeue) is answered straight from
// the idle state. An enqueue walks the new entry up from the tail slot and a
// dequeue walks the tail entry down from the root; a dequeue that removes the
// last entry finishes without a walk. Each walk step moves the entry one
// level; the slot memory's reads are registered, and its two read ports
// fetch both children at once. busy is high from the cycle after accept
// through the last walk cycle and is already low in the done cycle, so the
// next command can be taken there; a refused command never raises busy.
// Reset clears the entry count and the sequencer; the slot memory is not
// cleared, and only slots up to the count are ever read. Results cannot be
// stalled.
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                command,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]   item_value,
    input  wire logic [bmhq_pkg::TAG_W-1:0]          item_tag,
    output logic                                     done,
    output logic [bmhq_pkg::STATUS_W-1:0]            status,
    output logic signed [bmhq_pkg::KEY_W-1:0]        min_value,
    output logic [bmhq_pkg::TAG_W-1:0]               min_tag,
    output logic [bmhq_pkg::OCC_W-1:0]               occupancy
);

    // Heap indexes are one-based (1..CAPACITY); memory addresses are index-1.
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_IDX = IW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DQ_LOAD,
        S_UP,
        S_DOWN
    } state_t;

    state_t                             state_reg, state_next;
    logic [IW-1:0]                      count_reg, count_next;
    logic [IW-1:0]                      pos_reg, pos_next;
    bmhq_pkg::entry_t                   item_reg, item_next;
    logic                               done_reg, done_next;
    logic [bmhq_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic signed [bmhq_pkg::KEY_W-1:0]  min_value_reg, min_value_next;
    logic [bmhq_pkg::TAG_W-1:0]         min_tag_reg, min_tag_next;
    logic [bmhq_pkg::OCC_W-1:0]         occupancy_reg, occupancy_next;

    // Memory side
    logic                re_a, re_b, we;
    logic [IW-1:0]       rd_idx_a, rd_idx_b, wr_idx;
    bmhq_pkg::entry_t    rdata_a, rdata_b, wdata;

    // Walk helpers
    logic [IW-1:0]       cnt_inc;
    logic [IW-1:0]       walk_pos;
    logic [IW:0]         walk_kid;
    logic [IW:0]         child;
    logic [IW:0]         count_ext;
    logic [IW-1:0]       parent;
    logic                take_right;
    bmhq_pkg::entry_t    pick;
    logic [IW-1:0]       pick_idx;

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
        logic [IW-1:0] t;
        t = idx - ONE_IDX;
        return t[AW-1:0];
    endfunction

    bmhq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .re_a    (re_a),
        .addr_a  (to_addr(rd_idx_a)),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .addr_b  (to_addr(rd_idx_b)),
        .rdata_b (rdata_b),
        .we      (we),
        .waddr   (to_addr(wr_idx)),
        .wdata   (wdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        item_next      = item_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        min_value_next = min_value_reg;
        min_tag_next   = min_tag_reg;
        occupancy_next = occupancy_reg;

        re_a     = 1'b0;
        re_b     = 1'b0;
        rd_idx_a = ONE_IDX;
        rd_idx_b = ONE_IDX;
        we       = 1'b0;
        wr_idx   = pos_reg;
        wdata    = item_reg;

        cnt_inc   = count_reg + ONE_IDX;
        count_ext = {1'b0, count_reg};
        child     = {pos_reg, 1'b0};
        parent    = pos_reg >> 1;

        // Smaller child, left on a tie
        take_right = (child < count_ext) && ($signed(rdata_a.key) > $signed(rdata_b.key));
        pick       = take_right ? rdata_b : rdata_a;
        pick_idx   = take_right ? IW'(child + 1'b1) : IW'(child);

        walk_pos = pick_idx;
        walk_kid = {walk_pos, 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == bmhq_pkg::CMD_ENQ)
                    begin
                        min_value_next = '0;
                        min_tag_next   = '0;
                        if (count_reg >= CAP_IDX)
                        begin
                            // Refuse: heap full
                            done_next      = 1'b1;
                            status_next    = bmhq_pkg::ST_FULL;
                            occupancy_next = bmhq_pkg::OCC_W'(count_reg);
                        end
                        else
                        begin
                            count_next = cnt_inc;
                            pos_next   = cnt_inc;
                            item_next  = '{key: item_value, tag: item_tag};
                            // Fetch the parent of the new tail slot
                            re_a       = (count_reg != '0);
                            rd_idx_a   = cnt_inc >> 1;
                            state_next = S_UP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // Refuse: heap empty
                        done_next      = 1'b1;
                        status_next    = bmhq_pkg::ST_EMPTY;
                        min_value_next = '0;
                        min_tag_next   = '0;
                        occupancy_next = bmhq_pkg::OCC_W'(count_reg);
                    end
                    else
                    begin
                        // Fetch root and tail together
                        re_a       = 1'b1;
                        rd_idx_a   = ONE_IDX;
                        re_b       = 1'b1;
                        rd_idx_b   = count_reg;
                        count_next = count_reg - ONE_IDX;
                        state_next = S_DQ_LOAD;
                    end
                end
            end

            S_DQ_LOAD:
            begin
                min_value_next = rdata_a.key;
                min_tag_next   = rdata_a.tag;
                item_next      = rdata_b;
                pos_next       = ONE_IDX;
                if (count_reg == '0)
                begin
                    // Last entry removed; nothing to write back
                    done_next      = 1'b1;
                    status_next    = bmhq_pkg::ST_OK;
                    occupancy_next = bmhq_pkg::OCC_W'(count_reg);
                    state_next     = S_IDLE;
                end
                else
                begin
                    walk_pos   = ONE_IDX;
                    walk_kid   = {walk_pos, 1'b0};
                    re_a       = (walk_kid <= count_ext);
                    rd_idx_a   = IW'(walk_kid);
                    re_b       = ((walk_kid + 1'b1) <= count_ext);
                    rd_idx_b   = IW'(walk_kid + 1'b1);
                    state_next = S_DOWN;
                end
            end

            S_UP:
            begin
                if (pos_reg == ONE_IDX)
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if ($signed(item_reg.key) < $signed(rdata_a.key))
                begin
                    // Move parent down, climb one level
                    we       = 1'b1;
                    wdata    = rdata_a;
                    pos_next = parent;
                    re_a     = (parent != ONE_IDX);
                    rd_idx_a = parent >> 1;
                end
                else
                begin
                    we         = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                if (done_next)
                begin
                    status_next    = bmhq_pkg::ST_OK;
                    occupancy_next = bmhq_pkg::OCC_W'(count_reg);
                end
            end

            S_DOWN:
            begin
                if ((child <= count_ext) && ($signed(pick.key) < $signed(item_reg.key)))
                begin
                    // Move smaller child up, descend one level
                    we       = 1'b1;
                    wdata    = pick;
                    pos_next = pick_idx;
                    re_a     = (walk_kid <= count_ext);
                    rd_idx_a = IW'(walk_kid);
                    re_b     = ((walk_kid + 1'b1) <= count_ext);
                    rd_idx_b = IW'(walk_kid + 1'b1);
                end
                else
                begin
                    we             = 1'b1;
                    done_next      = 1'b1;
                    status_next    = bmhq_pkg::ST_OK;
                    occupancy_next = bmhq_pkg::OCC_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            pos_reg       <= '0;
            item_reg      <= '0;
            status_reg    <= '0;
            min_value_reg <= '0;
            min_tag_reg   <= '0;
            occupancy_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            pos_reg       <= pos_next;
            item_reg      <= item_next;
            status_reg    <= status_next;
            min_value_reg <= min_value_next;
            min_tag_reg   <= min_tag_next;
            occupancy_reg <= occupancy_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign min_value = min_value_reg;
    assign min_tag   = min_tag_reg;
    assign occupancy = occupancy_reg;

endmodule

`default_nettype wire
